/* hw/rtl/rsi_pkg.sv */
package rsi_pkg;

  localparam int TOL_W = 63;
  localparam logic [TOL_W-1:0] TOL_RESET = 63'd4295;

  // outcome of one query
  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_EXIT    = 2'd1,
    HIT_TANGENT = 2'd2,
    HIT_TWO     = 2'd3
  } hit_mode_t;

endpackage

/* hw/rtl/rsi_front.sv */
module rsi_front
  import rsi_pkg::*;
#(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [CW-1:0]      in_o [3],
  input  logic signed [F+2:0]       in_d [3],
  input  logic signed [CW-1:0]      in_c [3],
  input  logic [CW-2:0]             in_r,
  input  logic [TOL_W-1:0]          tol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [CW-1:0]      out_o [3],
  output logic signed [F+2:0]       out_d [3],
  output logic signed [F+CW+5:0]    out_a1,
  output hit_mode_t                 out_mode,
  output logic [2*(F+CW+6)-1:0]     out_rad
);

  localparam int DW   = F + 3;
  localparam int EW   = CW + 1;
  localparam int EEW  = 2 * EW;
  localparam int RW   = CW - 1;
  localparam int DEW  = DW + EW;
  localparam int A0W  = EEW + 2;
  localparam int A1W  = DEW + 2;
  localparam int HLO  = (A1W + 1) / 2;
  localparam int HHI  = A1W - HLO;
  localparam int SQW  = 2 * A1W;
  localparam int DSW  = SQW + 1;
  localparam int CMPW = (DSW > TOL_W + 2 * F) ? DSW : TOL_W + 2 * F;
  localparam int NST  = 8;

  logic [NST:1]   v_r;
  logic [NST+1:1] rdy;
  logic [NST:0]   vv;

  assign vv = {v_r, in_valid};
  assign rdy[NST+1] = out_ready;

  genvar g;
  generate
    for (g = 1; g <= NST; g++) begin : g_rdy
      assign rdy[g] = !v_r[g] || rdy[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vv[k-1];
        end
      end
    end
  end

  logic signed [CW-1:0]  o_r  [1:NST][3];
  logic signed [DW-1:0]  d_r  [1:NST][3];
  logic signed [A1W-1:0] a1_r [3:NST];
  logic signed [A0W-1:0] a0_r [3:7];

  logic signed [EW-1:0]  e1_r [3];
  logic [RW-1:0]         r1_r;
  logic signed [EEW-1:0] ee2_r [3];
  logic signed [DEW-1:0] de2_r [3];
  logic [2*RW-1:0]       rr2_r;
  logic [A1W-1:0]        mag4_r;
  logic [2*HHI-1:0]      hh5_r;
  logic [HHI+HLO-1:0]    hl5_r;
  logic [2*HLO-1:0]      ll5_r;
  logic [SQW-1:0]        sq6_r;
  logic signed [DSW-1:0] disc7_r;
  hit_mode_t             mode8_r;
  logic [SQW-1:0]        rad8_r;

  // carried operands
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      o_r[1] <= in_o;
      d_r[1] <= in_d;
    end
    for (int k = 2; k <= NST; k++) begin
      if (rdy[k]) begin
        o_r[k] <= o_r[k-1];
        d_r[k] <= d_r[k-1];
      end
    end
    for (int k = 4; k <= NST; k++) begin
      if (rdy[k]) begin
        a1_r[k] <= a1_r[k-1];
      end
    end
    for (int k = 4; k <= 7; k++) begin
      if (rdy[k]) begin
        a0_r[k] <= a0_r[k-1];
      end
    end
  end

  // stage 1: offset from center
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'(in_o[i]) - EW'(in_c[i]);
      end
      r1_r <= in_r;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        ee2_r[i] <= EEW'(e1_r[i]) * EEW'(e1_r[i]);
        de2_r[i] <= DEW'(d_r[1][i]) * DEW'(e1_r[i]);
      end
      rr2_r <= (2*RW)'(r1_r) * (2*RW)'(r1_r);
    end
  end

  // stage 3: a0 = |e|^2 - r^2, a1 = d.e
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      a0_r[3] <= A0W'(ee2_r[0]) + A0W'(ee2_r[1]) + A0W'(ee2_r[2])
                 - $signed(A0W'(rr2_r));
      a1_r[3] <= A1W'(de2_r[0]) + A1W'(de2_r[1]) + A1W'(de2_r[2]);
    end
  end

  // stage 4: |a1|
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      mag4_r <= a1_r[3][A1W-1] ? A1W'(-a1_r[3]) : A1W'(a1_r[3]);
    end
  end

  // stage 5: partial products of a1^2
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      hh5_r <= (2*HHI)'(mag4_r[A1W-1:HLO]) * (2*HHI)'(mag4_r[A1W-1:HLO]);
      hl5_r <= (HHI+HLO)'(mag4_r[A1W-1:HLO]) * (HHI+HLO)'(mag4_r[HLO-1:0]);
      ll5_r <= (2*HLO)'(mag4_r[HLO-1:0]) * (2*HLO)'(mag4_r[HLO-1:0]);
    end
  end

  // stage 6: a1^2
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sq6_r <= (SQW'(hh5_r) << (2 * HLO)) + (SQW'(hl5_r) << (HLO + 1)) + SQW'(ll5_r);
    end
  end

  // stage 7: discriminant
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      disc7_r <= $signed({1'b0, sq6_r}) - (DSW'(a0_r[6]) <<< (2 * F));
    end
  end

  // stage 8: classify
  logic           in_sphere;
  logic           tol_ok;
  logic [CMPW-1:0] disc_u;
  logic [CMPW-1:0] tol_sh;
  hit_mode_t      mode_nxt;

  assign disc_u = CMPW'($unsigned(disc7_r));
  assign tol_sh = CMPW'(tol) << (2 * F);
  assign in_sphere = a0_r[7][A0W-1] || (a0_r[7] == '0);
  assign tol_ok = disc_u >= tol_sh;

  always_comb begin
    if (in_sphere) begin
      mode_nxt = HIT_EXIT;
    end else if (a1_r[7][A1W-1] && !disc7_r[DSW-1]) begin
      mode_nxt = tol_ok ? HIT_TWO : HIT_TANGENT;
    end else begin
      mode_nxt = HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      mode8_r <= mode_nxt;
      rad8_r  <= (mode_nxt == HIT_EXIT || mode_nxt == HIT_TWO) ? disc7_r[SQW-1:0] : '0;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];
  assign out_o     = o_r[NST];
  assign out_d     = d_r[NST];
  assign out_a1    = a1_r[NST];
  assign out_mode  = mode8_r;
  assign out_rad   = rad8_r;

endmodule

/* hw/rtl/rsi_sqrt.sv */
module rsi_sqrt
  import rsi_pkg::*;
#(
  parameter int RTW = 54,
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2*RTW-1:0]   in_rad,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RTW-1:0]     out_root,
  output logic [SBW-1:0]     out_sb
);

  localparam int N     = RTW;
  localparam int RAD_W = 2 * RTW;

  logic [N:1]   v_r;
  logic [N+1:1] rdy;
  logic [N:0]   vv;

  logic [RAD_W-1:0] rem_r [1:N];
  logic [RTW-1:0]   q_r   [1:N];
  logic [SBW-1:0]   sb_r  [1:N];

  assign vv = {v_r, in_valid};
  assign rdy[N+1] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vv[k-1];
        end
      end
    end
  end

  // one root bit per stage, MSB first
  genvar k;
  generate
    for (k = 1; k <= N; k++) begin : g_stg
      logic [RAD_W-1:0] rem_in;
      logic [RTW-1:0]   q_in;
      logic [SBW-1:0]   sb_in;
      logic [RAD_W-1:0] trial;
      logic             ge;

      if (k == 1) begin : g_first
        assign rem_in = in_rad;
        assign q_in   = '0;
        assign sb_in  = in_sb;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign q_in   = q_r[k-1];
        assign sb_in  = sb_r[k-1];
      end

      assign rdy[k] = !v_r[k] || rdy[k+1];
      // (4q + 1) * 4^b
      assign trial  = RAD_W'({q_in, 2'b01}) << (2 * (N - k));
      assign ge     = rem_in >= trial;

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_r[k] <= ge ? rem_in - trial : rem_in;
          q_r[k]   <= {q_in[RTW-2:0], ge};
          sb_r[k]  <= sb_in;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[1];
  assign out_valid = v_r[N];
  assign out_root  = q_r[N];
  assign out_sb    = sb_r[N];

endmodule

/* hw/rtl/rsi_back.sv */
module rsi_back
  import rsi_pkg::*;
#(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [F+CW+5:0]        in_root,
  input  logic signed [F+CW+5:0] in_a1,
  input  hit_mode_t              in_mode,
  input  logic signed [CW-1:0]   in_o [3],
  input  logic signed [F+2:0]    in_d [3],
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_hit_count,
  output logic                   out_hits,
  output logic signed [CW-1:0]   out_t_near,
  output logic signed [CW-1:0]   out_t_far,
  output logic signed [CW-1:0]   out_p0 [3],
  output logic signed [CW-1:0]   out_p1 [3]
);

  localparam int DW  = F + 3;
  localparam int A1W = F + CW + 6;
  localparam int TW  = A1W + 2;
  localparam int PW  = CW + DW;
  localparam int AW  = PW + 1;
  localparam int XW  = (TW > AW) ? TW : AW;
  localparam int NST = 4;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [XW-1:0] v);
    logic ovf;
    ovf = (v[XW-1:CW-1] != '0) && (v[XW-1:CW-1] != '1);
    if (!ovf) begin
      sat_cw = v[CW-1:0];
    end else if (v[XW-1]) begin
      sat_cw = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_cw = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  logic [NST:1]   v_r;
  logic [NST+1:1] rdy;
  logic [NST:0]   vv;

  assign vv = {v_r, in_valid};
  assign rdy[NST+1] = out_ready;

  genvar g;
  generate
    for (g = 1; g <= NST; g++) begin : g_rdy
      assign rdy[g] = !v_r[g] || rdy[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vv[k-1];
        end
      end
    end
  end

  logic signed [CW-1:0] o_r [1:3][3];
  logic signed [DW-1:0] d_r [1:3][3];
  hit_mode_t            mode_r [1:3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      o_r[1]    <= in_o;
      d_r[1]    <= in_d;
      mode_r[1] <= in_mode;
    end
    for (int k = 2; k <= 3; k++) begin
      if (rdy[k]) begin
        o_r[k]    <= o_r[k-1];
        d_r[k]    <= d_r[k-1];
        mode_r[k] <= mode_r[k-1];
      end
    end
  end

  // stage 1: t with 2F fraction bits
  logic signed [TW-1:0] na1;
  logic signed [TW-1:0] rt;
  logic signed [TW-1:0] t0_1_r;
  logic signed [TW-1:0] t1_1_r;

  assign na1 = -TW'(in_a1);
  assign rt  = $signed(TW'(in_root));

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      case (in_mode)
        HIT_EXIT: begin
          t0_1_r <= na1 + rt;
          t1_1_r <= '0;
        end
        HIT_TANGENT: begin
          t0_1_r <= na1;
          t1_1_r <= '0;
        end
        HIT_TWO: begin
          t0_1_r <= na1 - rt;
          t1_1_r <= na1 + rt;
        end
        default: begin
          t0_1_r <= '0;
          t1_1_r <= '0;
        end
      endcase
    end
  end

  // stage 2: round half up, saturate
  logic signed [CW-1:0] t0_2_r;
  logic signed [CW-1:0] t1_2_r;
  logic signed [TW-1:0] half_t;

  assign half_t = TW'(1) <<< (F - 1);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t0_2_r <= sat_cw(XW'((t0_1_r + half_t) >>> F));
      t1_2_r <= sat_cw(XW'((t1_1_r + half_t) >>> F));
    end
  end

  // stage 3: t * d
  logic signed [PW-1:0] pr0_3_r [3];
  logic signed [PW-1:0] pr1_3_r [3];
  logic signed [CW-1:0] t0_3_r;
  logic signed [CW-1:0] t1_3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        pr0_3_r[i] <= PW'(t0_2_r) * PW'(d_r[2][i]);
        pr1_3_r[i] <= PW'(t1_2_r) * PW'(d_r[2][i]);
      end
      t0_3_r <= t0_2_r;
      t1_3_r <= t1_2_r;
    end
  end

  // stage 4: points, output register
  logic signed [AW-1:0] half_a;
  logic signed [CW-1:0] p0_nxt [3];
  logic signed [CW-1:0] p1_nxt [3];
  logic                 one_plus;
  logic                 two;

  assign half_a   = AW'(1) <<< (F - 1);
  assign one_plus = mode_r[3] != HIT_NONE;
  assign two      = mode_r[3] == HIT_TWO;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0_nxt[i] = sat_cw(XW'(((AW'(o_r[3][i]) <<< F) + AW'(pr0_3_r[i]) + half_a) >>> F));
      p1_nxt[i] = sat_cw(XW'(((AW'(o_r[3][i]) <<< F) + AW'(pr1_3_r[i]) + half_a) >>> F));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      out_hit_count <= two ? 2'd2 : (one_plus ? 2'd1 : 2'd0);
      out_hits      <= one_plus;
      out_t_near    <= one_plus ? t0_3_r : '0;
      out_t_far     <= two ? t1_3_r : '0;
      for (int i = 0; i < 3; i++) begin
        out_p0[i] <= one_plus ? p0_nxt[i] : '0;
        out_p1[i] <= two ? p1_nxt[i] : '0;
      end
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v_r[NST];

endmodule

/* hw/rtl/ray_sphere_intersection_core.sv */
// Ray / sphere intersection, fully pipelined.
// Order of the pipeline: front end, then square root, then back end;
// the square root takes one stage per root bit.
// Throughput: one query per cycle; stalls back up stage by stage, bubbles are absorbed.
// Reset (rst_n low, synchronous) empties the pipeline and loads the tangent
// tolerance with its default.
module ray_sphere_intersection_core
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [TOL_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [FRAC_BITS+2:0]   in_dir_x,
  input  logic signed [FRAC_BITS+2:0]   in_dir_y,
  input  logic signed [FRAC_BITS+2:0]   in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [COORD_WIDTH-2:0]        in_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_hit_count,
  output logic                          out_hits,
  output logic signed [COORD_WIDTH-1:0] out_t_near,
  output logic signed [COORD_WIDTH-1:0] out_t_far,
  output logic signed [COORD_WIDTH-1:0] out_p0_x,
  output logic signed [COORD_WIDTH-1:0] out_p0_y,
  output logic signed [COORD_WIDTH-1:0] out_p0_z,
  output logic signed [COORD_WIDTH-1:0] out_p1_x,
  output logic signed [COORD_WIDTH-1:0] out_p1_y,
  output logic signed [COORD_WIDTH-1:0] out_p1_z
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = FRAC_BITS + 3;
  localparam int A1W = FRAC_BITS + COORD_WIDTH + 6;
  localparam int SBW = 3 * CW + 3 * DW + A1W + 2;

  logic [TOL_W-1:0] tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  logic signed [CW-1:0]  in_o [3];
  logic signed [DW-1:0]  in_d [3];
  logic signed [CW-1:0]  in_c [3];

  assign in_o = '{in_origin_x, in_origin_y, in_origin_z};
  assign in_d = '{in_dir_x, in_dir_y, in_dir_z};
  assign in_c = '{in_center_x, in_center_y, in_center_z};

  logic                  fr_valid;
  logic                  fr_ready;
  logic signed [CW-1:0]  fr_o [3];
  logic signed [DW-1:0]  fr_d [3];
  logic signed [A1W-1:0] fr_a1;
  hit_mode_t             fr_mode;
  logic [2*A1W-1:0]      fr_rad;

  rsi_front #(
    .CW (CW),
    .F  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_o      (in_o),
    .in_d      (in_d),
    .in_c      (in_c),
    .in_r      (in_radius),
    .tol       (tol_r),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_o     (fr_o),
    .out_d     (fr_d),
    .out_a1    (fr_a1),
    .out_mode  (fr_mode),
    .out_rad   (fr_rad)
  );

  logic [SBW-1:0] sb_in;
  logic [SBW-1:0] sb_out;
  logic           sq_valid;
  logic           sq_ready;
  logic [A1W-1:0] sq_root;

  assign sb_in = {fr_o[0], fr_o[1], fr_o[2], fr_d[0], fr_d[1], fr_d[2], fr_a1, fr_mode};

  rsi_sqrt #(
    .RTW (A1W),
    .SBW (SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_sb     (sb_in),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_sb    (sb_out)
  );

  logic signed [CW-1:0]  bk_o [3];
  logic signed [DW-1:0]  bk_d [3];
  logic signed [A1W-1:0] bk_a1;
  hit_mode_t             bk_mode;
  logic signed [CW-1:0]  p0 [3];
  logic signed [CW-1:0]  p1 [3];

  assign bk_o[0] = sb_out[SBW-1 -: CW];
  assign bk_o[1] = sb_out[SBW-CW-1 -: CW];
  assign bk_o[2] = sb_out[SBW-2*CW-1 -: CW];
  assign bk_d[0] = sb_out[A1W+2+3*DW-1 -: DW];
  assign bk_d[1] = sb_out[A1W+2+2*DW-1 -: DW];
  assign bk_d[2] = sb_out[A1W+2+DW-1 -: DW];
  assign bk_a1   = sb_out[A1W+1:2];
  assign bk_mode = hit_mode_t'(sb_out[1:0]);

  rsi_back #(
    .CW (CW),
    .F  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sq_valid),
    .in_ready      (sq_ready),
    .in_root       (sq_root),
    .in_a1         (bk_a1),
    .in_mode       (bk_mode),
    .in_o          (bk_o),
    .in_d          (bk_d),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit_count (out_hit_count),
    .out_hits      (out_hits),
    .out_t_near    (out_t_near),
    .out_t_far     (out_t_far),
    .out_p0        (p0),
    .out_p1        (p1)
  );

  assign out_p0_x = p0[0];
  assign out_p0_y = p0[1];
  assign out_p0_z = p0[2];
  assign out_p1_x = p1[0];
  assign out_p1_y = p1[1];
  assign out_p1_z = p1[2];

  a_hits_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hits == (out_hit_count != 2'd0)))
    else $error("hits flag disagrees with hit count");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count != 2'd3))
    else $error("hit count out of range");

  a_far_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count != 2'd2) |->
      (out_t_far == '0 && out_p1_x == '0 && out_p1_y == '0 && out_p1_z == '0))
    else $error("second hit fields not cleared");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_count == 2'd0) |-> (out_t_near == '0 && out_p0_x == '0))
    else $error("first hit fields not cleared on a miss");

endmodule

/* tb/sv/ray_sphere_intersection_core_tb.sv */
`timescale 1ns / 1ps

module ray_sphere_intersection_core_tb;
  import rsi_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DW = FB + 3;
  localparam longint UNIT = 64'sd1 << FB;
  localparam int LATENCY = 8 + (FB + CW + 6) + 4;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [CW-1:0] o[3];
    logic signed [DW-1:0] d[3];
    logic signed [CW-1:0] c[3];
    logic [CW-2:0]        rad;
  } ray_query_t;

  typedef struct {
    logic [1:0]    cnt;
    logic          hits;
    logic [CW-1:0] tn;
    logic [CW-1:0] tf;
    logic [CW-1:0] p[6];
  } hit_result_t;

  class hit_scoreboard;
    hit_result_t   pending_hits[$];
    logic [TOL_W-1:0] tol;
    int            errors;
    int            checked;
    int            mode_cnt[4];

    function new();
      tol = TOL_RESET;
      errors = 0;
      checked = 0;
      foreach (mode_cnt[i]) mode_cnt[i] = 0;
    endfunction

    task report(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    function logic [127:0] root_floor(logic [127:0] n);
      logic [127:0] res, b, s;
      res = '0;
      b = 128'd1 << 126;
      while (b != 0) begin
        s = res + b;
        if (n >= s) begin
          n = n - s;
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // 2F fraction bits -> round half up to F bits, saturate
    function longint round_t(logic signed [127:0] t);
      logic signed [127:0] v;
      v = (t + 128'sd32768) >>> FB;
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return longint'(v);
    endfunction

    function longint hit_coord(longint o, longint t, longint d);
      longint acc;
      acc = (o * UNIT + t * d + (UNIT >>> 1)) >>> FB;
      if (acc > 64'sd2147483647) return 64'sd2147483647;
      if (acc < -64'sd2147483648) return -64'sd2147483648;
      return acc;
    endfunction

    function void note(ray_query_t q);
      logic signed [127:0] e[3], dv[3], r, a0, a1, disc, root, thr;
      longint t0, t1;
      hit_mode_t mode;
      hit_result_t x;
      t0 = 0;
      t1 = 0;
      a0 = '0;
      a1 = '0;
      r = {97'd0, q.rad};
      for (int i = 0; i < 3; i++) begin
        dv[i] = q.d[i];
        e[i] = q.o[i];
        e[i] = e[i] - q.c[i];
        a0 = a0 + e[i] * e[i];
        a1 = a1 + dv[i] * e[i];
      end
      a0 = a0 - r * r;
      disc = a1 * a1 - (a0 <<< (2 * FB));
      thr = $signed({65'd0, tol}) <<< (2 * FB);
      mode = HIT_NONE;
      if (a0 <= 0) begin
        root = root_floor(disc);
        t0 = round_t(-a1 + root);
        mode = HIT_EXIT;
      end else if (a1 < 0 && disc >= 0) begin
        if (disc >= thr) begin
          root = root_floor(disc);
          t0 = round_t(-a1 - root);
          t1 = round_t(-a1 + root);
          mode = HIT_TWO;
        end else begin
          t0 = round_t(-a1);
          mode = HIT_TANGENT;
        end
      end
      mode_cnt[int'(mode)]++;
      x.cnt = (mode == HIT_NONE) ? 2'd0 : (mode == HIT_TWO) ? 2'd2 : 2'd1;
      x.hits = (mode != HIT_NONE);
      x.tn = '0;
      x.tf = '0;
      foreach (x.p[i]) x.p[i] = '0;
      if (mode != HIT_NONE) begin
        x.tn = t0[CW-1:0];
        for (int i = 0; i < 3; i++) x.p[i] = CW'(hit_coord(q.o[i], t0, q.d[i]));
      end
      if (mode == HIT_TWO) begin
        x.tf = t1[CW-1:0];
        for (int i = 0; i < 3; i++) x.p[3+i] = CW'(hit_coord(q.o[i], t1, q.d[i]));
      end
      pending_hits.push_back(x);
    endfunction

    task check(hit_result_t got);
      hit_result_t w;
      if (pending_hits.size() == 0) begin
        report("unexpected result", got.tn, '0);
        return;
      end
      w = pending_hits.pop_front();
      if (got.cnt != w.cnt) report("hit_count", got.cnt, w.cnt);
      if (got.hits != w.hits) report("hits", got.hits, w.hits);
      if (got.tn != w.tn) report("t_near", got.tn, w.tn);
      if (got.tf != w.tf) report("t_far", got.tf, w.tf);
      for (int i = 0; i < 6; i++)
        if (got.p[i] != w.p[i]) report($sformatf("p%0d_%s", i / 3, (i % 3 == 0) ? "x" :
                                       (i % 3 == 1) ? "y" : "z"), got.p[i], w.p[i]);
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DW-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [CW-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [CW-2:0] in_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_hit_count;
  logic out_hits;
  logic signed [CW-1:0] out_t_near, out_t_far;
  logic signed [CW-1:0] out_p0_x, out_p0_y, out_p0_z, out_p1_x, out_p1_y, out_p1_z;

  hit_scoreboard sb = new();
  bit quiet = 1'b0;
  longint cycles = 0;
  int n_settings = 1;

  always #10 clk = ~clk;

  ray_sphere_intersection_core #(
    .COORD_WIDTH(CW),
    .FRAC_BITS(FB)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_radius(in_radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit_count(out_hit_count), .out_hits(out_hits),
    .out_t_near(out_t_near), .out_t_far(out_t_far),
    .out_p0_x(out_p0_x), .out_p0_y(out_p0_y), .out_p0_z(out_p0_z),
    .out_p1_x(out_p1_x), .out_p1_y(out_p1_y), .out_p1_z(out_p1_z)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ray_sphere_intersection_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    hit_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.cnt = out_hit_count;
      r.hits = out_hits;
      r.tn = out_t_near;
      r.tf = out_t_far;
      r.p[0] = out_p0_x; r.p[1] = out_p0_y; r.p[2] = out_p0_z;
      r.p[3] = out_p1_x; r.p[4] = out_p1_y; r.p[5] = out_p1_z;
      sb.check(r);
    end
  end

  // result-side backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic ray_query_t mk(longint ox, longint oy, longint oz, longint dx, longint dy,
                                    longint dz, longint cx, longint cy, longint cz, longint r);
    ray_query_t q;
    q.o[0] = CW'(ox); q.o[1] = CW'(oy); q.o[2] = CW'(oz);
    q.d[0] = DW'(dx); q.d[1] = DW'(dy); q.d[2] = DW'(dz);
    q.c[0] = CW'(cx); q.c[1] = CW'(cy); q.c[2] = CW'(cz);
    q.rad = (CW-1)'(r);
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint spread(int s);
    longint m;
    m = 64'sd1 << s;
    return longint'({$urandom(), $urandom()} % (2 * m + 1)) - m;
  endfunction

  function automatic real unit_rand();
    return real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
  endfunction

  function automatic ray_query_t any_query();
    ray_query_t q;
    for (int i = 0; i < 3; i++) begin
      q.o[i] = $urandom();
      q.c[i] = $urandom();
      q.d[i] = DW'($urandom_range(0, 262144) - 131072);
    end
    q.rad = (CW-1)'($urandom());
    return q;
  endfunction

  // ray aimed near the sphere, radius comparable to the distance
  function automatic ray_query_t scene_query();
    ray_query_t q;
    longint c[3], o[3];
    real v[3], len, span, jit;
    int s;
    s = $urandom_range(4, 30);
    span = 0.0;
    for (int i = 0; i < 3; i++) begin
      c[i] = clamp32(spread($urandom_range(4, 31)));
      o[i] = clamp32(c[i] + spread(s));
      q.c[i] = CW'(c[i]);
      q.o[i] = CW'(o[i]);
      span = span + real'(c[i] - o[i]) * real'(c[i] - o[i]);
    end
    span = $sqrt(span);
    jit = real'($urandom_range(0, 100)) / 100.0;
    len = 0.0;
    for (int i = 0; i < 3; i++) begin
      v[i] = ($urandom_range(0, 3) == 0) ? unit_rand() * (span + 1.0)
             : real'(c[i] - o[i]) + jit * span * unit_rand();
      len = len + v[i] * v[i];
    end
    len = $sqrt(len);
    if (len == 0.0) len = 1.0;
    for (int i = 0; i < 3; i++)
      q.d[i] = DW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 262144) - 131072
               : $rtoi(v[i] / len * 65536.0 + (v[i] >= 0.0 ? 0.5 : -0.5)));
    span = span * real'($urandom_range(20, 150)) / 100.0;
    if (span > 2147483647.0) span = 2147483647.0;
    q.rad = (CW-1)'($rtoi(span));
    return q;
  endfunction

  task automatic send(ray_query_t q);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_origin_x <= q.o[0]; in_origin_y <= q.o[1]; in_origin_z <= q.o[2];
    in_dir_x <= q.d[0]; in_dir_y <= q.d[1]; in_dir_z <= q.d[2];
    in_center_x <= q.c[0]; in_center_y <= q.c[1]; in_center_z <= q.c[2];
    in_radius <= q.rad;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note(q);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.tol = v;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TOL_W-1:0] tols[5];
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, default tolerance
    send(mk(-10 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, 0));              // exact tangent
    send(mk(-10 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, UNIT));           // two hits
    send(mk(0, 0, 0, 0, UNIT, 0, 0, 0, 0, 3 * UNIT));                // inside
    send(mk(2 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, 2 * UNIT));         // on surface
    send(mk(10 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, UNIT));            // pointing away
    send(mk(-10 * UNIT, 5 * UNIT, 0, UNIT, 0, 0, 0, 0, 0, UNIT));    // passes beside
    send(mk(-10 * UNIT, 0, 0, 0, 0, 0, 0, 0, 0, UNIT));              // zero direction
    send(mk(5, 7, 9, UNIT, 0, 0, 5, 7, 9, 0));                       // point sphere at origin
    send(mk(mn, mn, mn, 131072, 131072, 131072, mx, mx, mx, mx));    // far apart, max radius
    send(mk(mx, mx, mx, -131072, -131072, -131072, mn, mn, mn, 1));
    send(mk(mn, 0, mx, 131072, -131072, 0, mx, 0, mn, mx));
    send(mk(0, 0, 0, -131072, 131072, -131072, 0, 0, 0, mx));        // inside, saturates
    send(mk(mn, mn, mn, 131072, 131072, 131072, mn, mn, mn, mx));
    send(mk(-3 * UNIT, -3 * UNIT, 0, 46341, 46341, 0, 0, 0, 0, UNIT));
    send(mk(-100 * UNIT, 1, 0, UNIT, 0, 0, 0, 0, 0, 2));             // near-tangent

    tols[0] = TOL_RESET;
    tols[1] = '0;
    tols[2] = '1;
    tols[3] = 63'd1 << 45;
    tols[4] = TOL_W'({$urandom(), $urandom()});
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        set_tolerance(tols[ph]);
        send(mk(-10 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, 0));
        send(mk(-10 * UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0, UNIT));
        send(mk(-100 * UNIT, 1, 0, UNIT, 0, 0, 0, 0, 0, 2));
      end
      quiet = (ph == 4);
      for (int k = 0; k < 280; k++)
        send(($urandom_range(0, 5) == 0) ? any_query() : scene_query());
    end

    drain();
    $display("%0d queries checked across %0d tolerance settings", sb.checked, n_settings);
    $display("outcomes: %0d miss, %0d exit, %0d tangent, %0d two-hit",
             sb.mode_cnt[int'(HIT_NONE)], sb.mode_cnt[int'(HIT_EXIT)],
             sb.mode_cnt[int'(HIT_TANGENT)], sb.mode_cnt[int'(HIT_TWO)]);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("ray_sphere_intersection_core test passed");
    end else begin
      $display("ray_sphere_intersection_core test failed");
    end
    $finish;
  end

endmodule

/* ray_sphere_intersection_core.f */
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_front.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_back.sv
hw/rtl/ray_sphere_intersection_core.sv
tb/sv/ray_sphere_intersection_core_tb.sv
